// File: hw/rtl/ccs_pkg.sv
// Shared widths, codes and command tables of the camera command sequencer.
package ccs_pkg;

  localparam int LEN_W    = 16;
  localparam int MUL_B_W  = 7;
  localparam int PROD_W   = LEN_W + MUL_B_W;

  localparam logic [1:0] IN_START   = 2'd0;
  localparam logic [1:0] IN_RX      = 2'd1;
  localparam logic [1:0] IN_TIMEOUT = 2'd2;

  localparam logic [1:0] OUT_TX   = 2'd0;
  localparam logic [1:0] OUT_IMG  = 2'd1;
  localparam logic [1:0] OUT_DONE = 2'd2;

  localparam logic [2:0] CMD_STOP     = 3'd0;
  localparam logic [2:0] CMD_CAPTURE  = 3'd1;
  localparam logic [2:0] CMD_GET_LEN  = 3'd2;
  localparam logic [2:0] CMD_GET_IMG  = 3'd3;
  localparam logic [2:0] CMD_RESET    = 3'd4;
  localparam logic [2:0] CMD_NO_COMP  = 3'd5;
  localparam logic [2:0] CMD_COUNT    = 3'd6;

  localparam logic [4:0] CMD_TABLE_LEN = 5'd12;
  localparam logic [4:0] LEN_EXTRA     = 5'd4;

  localparam logic [7:0] MARK_HI = 8'hFF;
  localparam logic [7:0] MARK_LO = 8'hD8;

  localparam logic [MUL_B_W-1:0] PCT_FULL = 7'd100;
  localparam logic [6:0]         THR_RESET = 7'd95;

  function automatic logic [4:0] cmd_len(input logic [2:0] cid);
    case (cid)
      CMD_STOP:    cmd_len = 5'd5;
      CMD_CAPTURE: cmd_len = 5'd5;
      CMD_GET_LEN: cmd_len = 5'd5;
      CMD_GET_IMG: cmd_len = 5'd12;
      CMD_RESET:   cmd_len = 5'd4;
      CMD_NO_COMP: cmd_len = 5'd9;
      default:     cmd_len = 5'd0;
    endcase
  endfunction

  function automatic logic [7:0] cmd_byte(input logic [2:0] cid, input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx == 4'd0) begin
      b = 8'h56;
    end else if (idx == 4'd2) begin
      case (cid)
        CMD_STOP:    b = 8'h36;
        CMD_CAPTURE: b = 8'h36;
        CMD_GET_LEN: b = 8'h34;
        CMD_GET_IMG: b = 8'h32;
        CMD_RESET:   b = 8'h26;
        CMD_NO_COMP: b = 8'h31;
        default:     b = 8'h00;
      endcase
    end else begin
      case (cid)
        CMD_STOP: begin
          if (idx == 4'd3) b = 8'h01;
          else if (idx == 4'd4) b = 8'h03;
        end
        CMD_CAPTURE, CMD_GET_LEN: begin
          if (idx == 4'd3) b = 8'h01;
        end
        CMD_GET_IMG: begin
          if (idx == 4'd3) b = 8'h0C;
          else if (idx == 4'd5) b = 8'h0A;
        end
        CMD_NO_COMP: begin
          case (idx)
            4'd3:    b = 8'h05;
            4'd4:    b = 8'h01;
            4'd5:    b = 8'h01;
            4'd6:    b = 8'h12;
            4'd7:    b = 8'h04;
            default: b = 8'h00;
          endcase
        end
        default: b = 8'h00;
      endcase
    end
    cmd_byte = b;
  endfunction

  function automatic logic [2:0] ack_len(input logic [2:0] cid);
    case (cid)
      CMD_STOP:    ack_len = 3'd5;
      CMD_CAPTURE: ack_len = 3'd5;
      CMD_GET_LEN: ack_len = 3'd7;
      CMD_GET_IMG: ack_len = 3'd7;
      CMD_NO_COMP: ack_len = 3'd5;
      default:     ack_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] ack_byte(input logic [2:0] cid, input logic [2:0] pos);
    logic [7:0] b;
    b = 8'h00;
    case (pos)
      3'd0: b = 8'h76;
      3'd2: begin
        case (cid)
          CMD_STOP, CMD_CAPTURE: b = 8'h36;
          CMD_GET_LEN:           b = 8'h34;
          CMD_GET_IMG:           b = 8'h32;
          CMD_NO_COMP:           b = 8'h31;
          default:               b = 8'h00;
        endcase
      end
      3'd4: b = (cid == CMD_GET_LEN) ? 8'h04 : 8'h00;
      3'd5: b = (cid == CMD_GET_IMG) ? MARK_HI : 8'h00;
      3'd6: b = (cid == CMD_GET_IMG) ? MARK_LO : 8'h00;
      default: b = 8'h00;
    endcase
    ack_byte = b;
  endfunction

endpackage

// File: hw/rtl/camera_command_sequencer.sv
// Top level of the camera command sequencer.
//
// Input channel (in_valid/in_ready): one item is a start command, a byte
// received from the camera or a read timeout. in_ready is high only while the
// sequencer is idle; an item is taken while in_ready is high and its results follow.
// Result channel (out_valid/out_ready): bytes to transmit, image data bytes
// and command-finished results, the final result of each item flagged by
// out_last. A start item for a valid command, taken while no command is active,
// yields 4 to 16 bytes at one per cycle while the receiver takes them, plus a
// finish result where the acknowledge is empty. A received byte yields 0 to 3
// results at one per cycle while the receiver takes them. An image timeout runs
// two 7-step products on the shared shift-add multiplier before its finish result.
// cfg_wr_en/cfg_wr_data write the registered received-percentage threshold.
// Reset: threshold 95, sequencer idle, stored image length zero.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; no result is lost or repeated.
module camera_command_sequencer
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [2:0] in_command_id,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_ok,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_MUL} st_t;
  typedef enum logic [2:0] {PH_IDLE, PH_ACK, PH_LEN_HI, PH_LEN_LO, PH_IMAGE} phase_t;
  typedef enum logic [1:0] {SRC_CMD, SRC_MARK, SRC_RX} src_t;

  st_t              st_r;
  phase_t           phase_r;
  logic [2:0]       active_r;
  logic [2:0]       ackpos_r;
  logic [7:0]       len_hi_r;
  logic [7:0]       len_lo_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] total_r;
  logic [6:0]       thr_r;

  src_t             em_src_r;
  logic [4:0]       em_cnt_r;
  logic [4:0]       em_idx_r;
  logic             em_fin_r;
  logic             em_ok_r;
  logic [7:0]       rx_r;

  logic             mul_start_r;
  logic             mul_sel_r;
  logic [PROD_W-1:0] prod_a_r;

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_byte_r;
  logic             out_ok_r;
  logic             out_last_r;

  logic             out_free;
  logic             in_fire;
  logic [2:0]       cur_ack_len;
  logic             ack_hit;
  logic [2:0]       ack_next;
  logic [LEN_W-1:0] len_word;
  logic [7:0]       em_byte;
  logic [LEN_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic             mul_done;
  logic [PROD_W-1:0] mul_prod;

  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (st_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign cur_ack_len = ack_len(active_r);
  assign ack_hit     = (ackpos_r < cur_ack_len) && (ack_byte(active_r, ackpos_r) == in_rx_byte);
  assign ack_next    = ackpos_r + 3'd1;
  assign len_word    = {len_hi_r, len_lo_r};

  always_comb begin
    unique case (em_src_r)
      SRC_CMD: begin
        if (em_idx_r < CMD_TABLE_LEN) em_byte = cmd_byte(active_r, em_idx_r[3:0]);
        else if (em_idx_r == CMD_TABLE_LEN) em_byte = len_hi_r;
        else if (em_idx_r == CMD_TABLE_LEN + 5'd1) em_byte = len_lo_r;
        else em_byte = 8'h00;
      end
      SRC_MARK: em_byte = (em_idx_r == 5'd0) ? MARK_HI : MARK_LO;
      SRC_RX:   em_byte = rx_r;
      default:  em_byte = 8'h00;
    endcase
  end

  assign mul_a = mul_sel_r ? total_r : (total_r - rem_r);
  assign mul_b = mul_sel_r ? thr_r : PCT_FULL;

  ccs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_IDLE;
      active_r    <= 3'd0;
      ackpos_r    <= 3'd0;
      len_hi_r    <= 8'd0;
      len_lo_r    <= 8'd0;
      rem_r       <= '0;
      total_r     <= '0;
      thr_r       <= THR_RESET;
      em_src_r    <= SRC_CMD;
      em_cnt_r    <= 5'd0;
      em_idx_r    <= 5'd0;
      em_fin_r    <= 1'b0;
      mul_start_r <= 1'b0;
      mul_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (out_valid_r && out_ready && st_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (in_fire) begin
            em_idx_r <= 5'd0;
            em_cnt_r <= 5'd0;
            em_fin_r <= 1'b0;
            em_ok_r  <= 1'b0;
            rx_r     <= in_rx_byte;
            unique case (in_kind)
              IN_START: begin
                if (phase_r == PH_IDLE && in_command_id < CMD_COUNT) begin
                  active_r <= in_command_id;
                  ackpos_r <= 3'd0;
                  em_src_r <= SRC_CMD;
                  em_cnt_r <= cmd_len(in_command_id) +
                              ((in_command_id == CMD_GET_IMG) ? LEN_EXTRA : 5'd0);
                  if (ack_len(in_command_id) == 3'd0) begin
                    em_fin_r <= 1'b1;
                    em_ok_r  <= 1'b1;
                  end else begin
                    phase_r  <= PH_ACK;
                  end
                  st_r <= S_EMIT;
                end
              end
              IN_RX: begin
                unique case (phase_r)
                  PH_ACK: begin
                    if (!ack_hit) begin
                      em_fin_r <= 1'b1;
                      phase_r  <= PH_IDLE;
                      ackpos_r <= 3'd0;
                      st_r     <= S_EMIT;
                    end else if (ack_next == cur_ack_len) begin
                      ackpos_r <= 3'd0;
                      if (active_r == CMD_GET_LEN) begin
                        phase_r <= PH_LEN_HI;
                      end else if (active_r == CMD_GET_IMG) begin
                        em_src_r <= SRC_MARK;
                        em_cnt_r <= 5'd2;
                        total_r  <= len_word;
                        rem_r    <= len_word;
                        if (len_word == '0) begin
                          em_fin_r <= 1'b1;
                          em_ok_r  <= 1'b1;
                          phase_r  <= PH_IDLE;
                        end else begin
                          phase_r  <= PH_IMAGE;
                        end
                        st_r <= S_EMIT;
                      end else begin
                        em_fin_r <= 1'b1;
                        em_ok_r  <= 1'b1;
                        phase_r  <= PH_IDLE;
                        st_r     <= S_EMIT;
                      end
                    end else begin
                      ackpos_r <= ack_next;
                    end
                  end
                  PH_LEN_HI: begin
                    len_hi_r <= in_rx_byte;
                    phase_r  <= PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                    len_lo_r <= in_rx_byte;
                    em_fin_r <= 1'b1;
                    em_ok_r  <= 1'b1;
                    phase_r  <= PH_IDLE;
                    ackpos_r <= 3'd0;
                    st_r     <= S_EMIT;
                  end
                  PH_IMAGE: begin
                    em_src_r <= SRC_RX;
                    em_cnt_r <= 5'd1;
                    rem_r    <= rem_r - LEN_W'(1);
                    if (rem_r == LEN_W'(1)) begin
                      em_fin_r <= 1'b1;
                      em_ok_r  <= 1'b1;
                      phase_r  <= PH_IDLE;
                      ackpos_r <= 3'd0;
                    end
                    st_r <= S_EMIT;
                  end
                  default: begin
                  end
                endcase
              end
              IN_TIMEOUT: begin
                if (phase_r == PH_ACK || phase_r == PH_LEN_HI || phase_r == PH_LEN_LO) begin
                  em_fin_r <= 1'b1;
                  phase_r  <= PH_IDLE;
                  ackpos_r <= 3'd0;
                  st_r     <= S_EMIT;
                end else if (phase_r == PH_IMAGE) begin
                  mul_sel_r   <= 1'b0;
                  mul_start_r <= 1'b1;
                  st_r        <= S_MUL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (em_idx_r < em_cnt_r) begin
              out_kind_r <= (em_src_r == SRC_CMD) ? OUT_TX : OUT_IMG;
              out_byte_r <= em_byte;
              out_ok_r   <= 1'b0;
              out_last_r <= (em_idx_r == em_cnt_r - 5'd1) && !em_fin_r;
              em_idx_r   <= em_idx_r + 5'd1;
              if (em_idx_r == em_cnt_r - 5'd1 && !em_fin_r) st_r <= S_IDLE;
            end else begin
              out_kind_r <= OUT_DONE;
              out_byte_r <= 8'h00;
              out_ok_r   <= em_ok_r;
              out_last_r <= 1'b1;
              st_r       <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            if (!mul_sel_r) begin
              prod_a_r    <= mul_prod;
              mul_sel_r   <= 1'b1;
              mul_start_r <= 1'b1;
            end else begin
              em_idx_r <= 5'd0;
              em_cnt_r <= 5'd0;
              em_fin_r <= 1'b1;
              em_ok_r  <= (prod_a_r > mul_prod);
              phase_r  <= PH_IDLE;
              ackpos_r <= 3'd0;
              st_r     <= S_EMIT;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_ok    = out_ok_r;
  assign out_last  = out_last_r;

  a_mul_only_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> st_r == S_MUL)
    else $error("multiplier result outside the timeout check");

  a_ackpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ackpos_r != 3'd7)
    else $error("acknowledge position out of range");

  a_image_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IMAGE |-> rem_r != '0)
    else $error("image phase with no bytes remaining");

  a_emit_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_EMIT |-> em_idx_r <= em_cnt_r && em_cnt_r <= 5'd16)
    else $error("emission index beyond count");

  a_emit_work: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_EMIT |-> em_idx_r < em_cnt_r || em_fin_r)
    else $error("emission state with nothing to send");

endmodule

// File: hw/rtl/ccs_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, shared by the timeout check.
module ccs_mul
  import ccs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [LEN_W-1:0]    a,
  input  logic [MUL_B_W-1:0]  b,
  output logic                done,
  output logic [PROD_W-1:0]   product
);

  logic [PROD_W-1:0]  acc_r;
  logic [PROD_W-1:0]  a_sh_r;
  logic [MUL_B_W-1:0] b_r;
  logic [2:0]         cnt_r;
  logic               busy_r;
  logic               done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r  <= '0;
        a_sh_r <= {{MUL_B_W{1'b0}}, a};
        b_r    <= b;
        cnt_r  <= 3'(MUL_B_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r[0]) acc_r <= acc_r + a_sh_r;
        a_sh_r <= {a_sh_r[PROD_W-2:0], 1'b0};
        b_r    <= {1'b0, b_r[MUL_B_W-1:1]};
        cnt_r  <= cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("multiplier done without a finished run");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiplier started while busy");

  a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != 3'd0 |=> busy_r)
    else $error("multiplier run ended early");

endmodule
